// ----- sv/pbs_pkg.sv -----
// Package with the shared types and constants of the priority batch scheduler.
`timescale 1ns / 1ps
`default_nettype none
package pbs_pkg;

    localparam int ID_W   = 16;
    localparam int PRIO_W = 16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic clear;
        logic scan_init;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic scan_done;
        logic last;
    } t_status;

endpackage
`default_nettype wire

// ----- sv/priority_batch_scheduler.sv -----
// Top level of the priority batch scheduler: controller, datapath and assertions.
`timescale 1ns / 1ps
`default_nettype none
// An item is taken when start is high and busy is low. An item with
// i_end_of_batch low loads one process entry into the next free table slot;
// busy stays low, and loads may follow on every cycle. When the table already
// holds CAPACITY entries the entry is dropped and the batch is marked as
// having dropped something. An item with i_end_of_batch high drains the table:
// busy rises and the block emits one result per loaded entry, highest
// priority first, earliest arrival on ties. Each result is shown for one
// cycle with o_strobe high; o_final_result marks the last one and
// o_dropped_any reports a drop in the batch. Before each result a linear scan
// reads the entry memory one slot per cycle over the N slots loaded in the
// batch. busy falls in the cycle of the last result. An empty drain gives no
// result and busy stays low.
// The receiver cannot stall the block.
// Reset empties the table and clears the drop flag; entry contents are left.
module priority_batch_scheduler #(
    parameter int CAPACITY = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       i_end_of_batch,
    input  wire logic [pbs_pkg::ID_W-1:0]   i_process_id,
    input  wire logic [pbs_pkg::PRIO_W-1:0] i_prio_value,
    output logic                            o_strobe,
    output logic [pbs_pkg::ID_W-1:0]        o_served_id,
    output logic [pbs_pkg::PRIO_W-1:0]      o_served_prio,
    output logic                            o_final_result,
    output logic                            o_dropped_any
);
    import pbs_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_state  state;

    pbs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_end_of_batch (i_end_of_batch),
        .i_status       (status),
        .busy           (busy),
        .o_cmd          (cmd),
        .o_state        (state)
    );

    pbs_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_process_id   (i_process_id),
        .i_prio_value   (i_prio_value),
        .o_status       (status),
        .o_strobe       (o_strobe),
        .o_served_id    (o_served_id),
        .o_served_prio  (o_served_prio),
        .o_final_result (o_final_result),
        .o_dropped_any  (o_dropped_any)
    );

    a_strobe_follows_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state == S_EMIT) |=> o_strobe)
        else $error("emit state not followed by a result strobe");

    a_strobe_isolated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two results on consecutive cycles");

    a_strobe_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without a drain in progress");

    a_no_load_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !cmd.load && !cmd.clear)
        else $error("table changed by an item during a drain");

endmodule
`default_nettype wire

// ----- sv/pbs_ctrl.sv -----
// Controller state machine of the priority batch scheduler.
`timescale 1ns / 1ps
`default_nettype none
module pbs_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire logic            i_end_of_batch,
    input  wire pbs_pkg::t_status i_status,
    output logic                 busy,
    output pbs_pkg::t_cmd        o_cmd,
    output pbs_pkg::t_state      o_state
);
    import pbs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start && i_end_of_batch && !i_status.count_zero) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_state = i_status.last ? S_IDLE : S_SCAN;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load      = start && !i_end_of_batch;
                o_cmd.clear     = start && i_end_of_batch && i_status.count_zero;
                o_cmd.scan_init = start && i_end_of_batch && !i_status.count_zero;
            end
            S_SCAN: begin
                o_cmd = '0;
            end
            S_EMIT: begin
                o_cmd.emit      = 1'b1;
                o_cmd.scan_init = !i_status.last;
            end
            default: o_cmd = '0;
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_state = r_state;

endmodule
`default_nettype wire

// ----- sv/pbs_dp.sv -----
// Datapath of the priority batch scheduler: entry table, scan engine and result registers.
`timescale 1ns / 1ps
`default_nettype none
module pbs_dp #(
    parameter int CAPACITY = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire pbs_pkg::t_cmd           i_cmd,
    input  wire logic [pbs_pkg::ID_W-1:0]   i_process_id,
    input  wire logic [pbs_pkg::PRIO_W-1:0] i_prio_value,
    output pbs_pkg::t_status             o_status,
    output logic                         o_strobe,
    output logic [pbs_pkg::ID_W-1:0]     o_served_id,
    output logic [pbs_pkg::PRIO_W-1:0]   o_served_prio,
    output logic                         o_final_result,
    output logic                         o_dropped_any
);
    import pbs_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ENT_W = ID_W + PRIO_W;

    logic [ENT_W-1:0]    r_mem [CAPACITY];
    logic [ENT_W-1:0]    r_rd_data;
    logic [CAPACITY-1:0] r_valid;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_remain;
    logic                r_ovf;
    logic [IDX_W-1:0]    r_addr;
    logic                r_issue;
    logic                r_cmp_en;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic                r_best_found;
    logic [IDX_W-1:0]    r_best_idx;
    logic [ID_W-1:0]     r_best_id;
    logic [PRIO_W-1:0]   r_best_prio;
    logic                r_out_stb;
    logic [ID_W-1:0]     r_out_id;
    logic [PRIO_W-1:0]   r_out_prio;
    logic                r_out_final;
    logic                r_out_drop;

    logic                n_full;
    logic [CNT_W-1:0]    n_last_idx;
    logic [PRIO_W-1:0]   n_rd_prio;
    logic                n_take;

    assign n_full     = (r_count == CNT_W'(CAPACITY));
    assign n_last_idx = r_count - CNT_W'(1);
    assign n_rd_prio  = r_rd_data[PRIO_W-1:0];
    assign n_take     = r_cmp_en && r_valid[r_cmp_idx]
                        && (!r_best_found || (n_rd_prio > r_best_prio));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !n_full) begin
            r_mem[r_count[IDX_W-1:0]] <= {i_process_id, i_prio_value};
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_count  <= '0;
            r_remain <= '0;
            r_ovf    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (n_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_valid[r_count[IDX_W-1:0]] <= 1'b1;
                    r_count  <= r_count + CNT_W'(1);
                    r_remain <= r_remain + CNT_W'(1);
                end
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_valid[r_best_idx] <= 1'b0;
                r_remain <= r_remain - CNT_W'(1);
                if (o_status.last) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_issue      <= 1'b0;
            r_cmp_en     <= 1'b0;
            r_best_found <= 1'b0;
        end else begin
            r_cmp_en <= r_issue;
            if (i_cmd.scan_init) begin
                r_addr       <= '0;
                r_issue      <= 1'b1;
                r_best_found <= 1'b0;
            end else begin
                if (r_issue) begin
                    r_addr <= r_addr + IDX_W'(1);
                    if (CNT_W'(r_addr) == n_last_idx) begin
                        r_issue <= 1'b0;
                    end
                end
                if (n_take) begin
                    r_best_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_addr;
        if (n_take) begin
            r_best_idx  <= r_cmp_idx;
            r_best_id   <= r_rd_data[ENT_W-1:PRIO_W];
            r_best_prio <= n_rd_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_stb <= 1'b0;
        end else begin
            r_out_stb <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_id    <= r_best_id;
            r_out_prio  <= r_best_prio;
            r_out_final <= o_status.last;
            r_out_drop  <= r_ovf;
        end
    end

    assign o_status.count_zero = (r_count == '0);
    assign o_status.scan_done  = r_cmp_en && (CNT_W'(r_cmp_idx) == n_last_idx);
    assign o_status.last       = (r_remain == CNT_W'(1));

    assign o_strobe       = r_out_stb;
    assign o_served_id    = r_out_id;
    assign o_served_prio  = r_out_prio;
    assign o_final_result = r_out_final;
    assign o_dropped_any  = r_out_drop;

endmodule
`default_nettype wire
